// File: hdl/sdas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdas_pkg: shared types and constants
// Transaction structs, request and operation codes, sequencer states.
// ----------------------------------------------------------------------------
package sdas_pkg;

  localparam int OperandDigits = 32;
  localparam int WorkDepth     = 2 * OperandDigits;
  localparam int IdxW          = $clog2(OperandDigits);
  localparam int LenW          = $clog2(OperandDigits + 1);
  localparam int WIdxW         = $clog2(WorkDepth);

  localparam logic [1:0] ReqFirst  = 2'd0;
  localparam logic [1:0] ReqSecond = 2'd1;
  localparam logic [1:0] ReqRun    = 2'd2;

  localparam logic [1:0] OpAdd = 2'd0;
  localparam logic [1:0] OpSub = 2'd1;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] digit;
    logic       negative;
    logic [1:0] op;
  } req_t;

  typedef struct packed {
    logic [3:0] digit_res;
    logic       negative_res;
    logic       last;
    logic       too_long;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_MUL,
    ST_ADD,
    ST_FETCH,
    ST_EMIT
  } state_e;

endpackage
`default_nettype wire

// File: hdl/signed_decimal_add_sub_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// signed_decimal_add_sub_mul: signed decimal add, subtract and multiply
// Load operands a digit at a time, then run one operation and stream the
// result digits out, most significant first.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake        | Payload
// req     | in        | req_valid_i/stall| req_t (req_type, digit, negative, op)
// rsp     | out       | rsp_valid_o/stall| rsp_t (digit_res, negative_res, last,
//         |           |                  |        too_long)
//
// A run walks the digit memories with one shared pair of digit reads: first a
// magnitude compare over up to 32 digit pairs (it stops after the first
// differing digit pair); then add/subtract writes the 64 work digits, or
// multiply builds each of the 64 result columns from 32 digit products plus
// a carry step; then a fetch step and the emit of the result digits, which
// waits while the output stalls.
// Reset clears lengths, signs and the flag; every run rewrites all work digits.
// A stalled output holds its digit; the sequencer waits on it.
// ----------------------------------------------------------------------------
module signed_decimal_add_sub_mul (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           req_valid_i,
  output logic                req_stall_o,
  input  wire sdas_pkg::req_t req_i,
  output logic                rsp_valid_o,
  input  wire logic           rsp_stall_i,
  output sdas_pkg::rsp_t      rsp_o
);
  import sdas_pkg::*;

  // operand and work storage
  logic [3:0]  a_mem [OperandDigits];
  logic [3:0]  b_mem [OperandDigits];
  logic [3:0]  w_mem [WorkDepth];

  logic [LenW-1:0] a_len_q, b_len_q;
  logic            a_sign_q, b_sign_q, drop_q;
  state_e          state_q, state_d;
  logic [IdxW-1:0] i_q;
  logic [WIdxW-1:0] k_q, top_q;
  logic [11:0]     sum_q;
  logic            carry_q, fin_q;
  logic            eff_add_q, is_mul_q, swap_q, cmp_done_q, sign_q, nz_q;
  logic            last_step;

  rsp_t rsp_q;
  logic rsp_valid_q;
  logic [3:0] rd_q;

  // digit read addresses: compare and add walk both operands at one index,
  // multiply pairs a[i] with b[k - i] for result column k
  logic [IdxW-1:0] a_idx, b_idx;
  logic            a_ok, b_ok;
  logic [WIdxW:0]  kd;
  assign kd = {1'b0, k_q} - (WIdxW + 1)'(i_q);

  always_comb begin
    a_idx = '0;
    b_idx = '0;
    a_ok  = 1'b0;
    b_ok  = 1'b0;
    case (state_q)
      ST_CMP: begin
        a_idx = i_q;
        b_idx = i_q;
        a_ok  = 1'b1;
        b_ok  = 1'b1;
      end
      ST_ADD: begin
        a_idx = k_q[IdxW-1:0];
        b_idx = k_q[IdxW-1:0];
        a_ok  = (k_q < WIdxW'(OperandDigits));
        b_ok  = a_ok;
      end
      ST_MUL: begin
        a_idx = i_q;
        b_idx = kd[IdxW-1:0];
        a_ok  = 1'b1;
        b_ok  = (kd < (WIdxW + 1)'(OperandDigits));
      end
      default: ;
    endcase
  end

  // digit reads with length masking
  logic [3:0] da, db, big, sml;
  assign da = (a_ok && (LenW'(a_idx) < a_len_q)) ? a_mem[a_idx] : 4'd0;
  assign db = (b_ok && (LenW'(b_idx) < b_len_q)) ? b_mem[b_idx] : 4'd0;
  assign big = swap_q ? db : da;
  assign sml = swap_q ? da : db;

  // one digit of add or subtract
  logic [4:0] asum, dsub;
  logic [3:0] add_dig, sub_dig;
  logic       add_cy, sub_bw;
  assign asum    = {1'b0, da} + {1'b0, db} + {4'd0, carry_q};
  assign add_cy  = (asum >= 5'd10);
  assign add_dig = add_cy ? 4'(asum - 5'd10) : asum[3:0];
  assign dsub    = {1'b0, sml} + {4'd0, carry_q};
  assign sub_bw  = ({1'b0, big} < dsub);
  assign sub_dig = sub_bw ? 4'({1'b0, big} + 5'd10 - dsub) : 4'({1'b0, big} - dsub);

  // column accumulate, and split of the column total into digit and carry
  logic [7:0]  prod;
  logic [11:0] sum_nx, q10, ten_x;
  logic [23:0] recip;
  logic [3:0]  rem_dig;
  assign prod    = da * db;
  assign sum_nx  = sum_q + {4'd0, prod};
  // divide by ten via reciprocal, column total stays below 4096
  assign recip   = 24'(sum_q) * 24'd3277;
  assign q10     = 12'(recip >> 15);
  assign ten_x   = q10 * 12'd10;
  assign rem_dig = 4'(sum_q - ten_x);

  // single write port into the work digits, top digit tracked on the way
  logic             w_we, wr_nz, wr_last, nz_fin;
  logic [3:0]       w_data;
  logic [WIdxW-1:0] top_fin, rd_addr;
  logic             emit_fire;
  assign w_we    = (state_q == ST_ADD) || (state_q == ST_MUL && fin_q);
  assign w_data  = (state_q == ST_MUL) ? rem_dig : (eff_add_q ? add_dig : sub_dig);
  assign wr_nz   = w_we && (w_data != 4'd0);
  assign wr_last = w_we && (k_q == WIdxW'(WorkDepth - 1));
  assign top_fin = wr_nz ? k_q : top_q;
  assign nz_fin  = nz_q || wr_nz;

  assign emit_fire = (state_q == ST_EMIT) && (!rsp_valid_q || !rsp_stall_i);
  assign last_step = emit_fire && (k_q == '0);
  // read ahead the next lower digit as soon as the current one is taken
  assign rd_addr   = emit_fire ? k_q - 1'b1 : k_q;

  assign req_stall_o = (state_q != ST_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  logic acc;
  assign acc = req_valid_i && !req_stall_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (acc && req_i.req_type == ReqRun) begin
        state_d = ST_CMP;
      end
      ST_CMP:  if (i_q == '0 || cmp_done_q) begin
        state_d = is_mul_q ? ST_MUL : ST_ADD;
      end
      ST_MUL:  if (wr_last) begin
        state_d = ST_FETCH;
      end
      ST_ADD:  if (wr_last) begin
        state_d = ST_FETCH;
      end
      ST_FETCH: state_d = ST_EMIT;
      ST_EMIT: if (last_step) begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && acc) begin
      if (req_i.req_type == ReqFirst && a_len_q < LenW'(OperandDigits)) begin
        a_mem[a_len_q[IdxW-1:0]] <= (req_i.digit > 4'd9) ? 4'd9 : req_i.digit;
      end
      if (req_i.req_type == ReqSecond && b_len_q < LenW'(OperandDigits)) begin
        b_mem[b_len_q[IdxW-1:0]] <= (req_i.digit > 4'd9) ? 4'd9 : req_i.digit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (w_we) begin
      w_mem[k_q] <= w_data;
    end
    rd_q <= w_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_len_q <= '0; b_len_q <= '0; a_sign_q <= 1'b0; b_sign_q <= 1'b0;
      drop_q <= 1'b0; rsp_valid_q <= 1'b0; rsp_q <= '0;
      i_q <= '0; k_q <= '0; top_q <= '0; sum_q <= '0; carry_q <= 1'b0;
      fin_q <= 1'b0;
      eff_add_q <= 1'b0; is_mul_q <= 1'b0; swap_q <= 1'b0; cmp_done_q <= 1'b0;
      sign_q <= 1'b0; nz_q <= 1'b0;
    end else begin
      if (emit_fire) begin
        rsp_valid_q <= 1'b1;
      end else if (!rsp_stall_i) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: if (acc) begin
          if (req_i.req_type == ReqFirst) begin
            a_sign_q <= req_i.negative;
            if (a_len_q < LenW'(OperandDigits)) a_len_q <= a_len_q + 1'b1;
            else drop_q <= 1'b1;
          end else if (req_i.req_type == ReqSecond) begin
            b_sign_q <= req_i.negative;
            if (b_len_q < LenW'(OperandDigits)) b_len_q <= b_len_q + 1'b1;
            else drop_q <= 1'b1;
          end else if (req_i.req_type == ReqRun) begin
            is_mul_q  <= req_i.op[1];
            eff_add_q <= (a_sign_q == (b_sign_q ^ (req_i.op == OpSub)));
            b_sign_q  <= b_sign_q ^ (req_i.op == OpSub);
            sign_q    <= req_i.op[1] ? (a_sign_q ^ b_sign_q) : a_sign_q;
            i_q <= IdxW'(OperandDigits - 1); k_q <= '0;
            top_q <= '0; nz_q <= 1'b0; sum_q <= '0; fin_q <= 1'b0;
            swap_q <= 1'b0; cmp_done_q <= 1'b0; carry_q <= 1'b0;
          end
        end
        ST_CMP: begin
          // compare from the top digit down, stop at first difference
          if (i_q == '0 || cmp_done_q) begin
            if (!eff_add_q && !is_mul_q) begin
              sign_q <= (cmp_done_q ? swap_q : (da < db)) ? b_sign_q : a_sign_q;
              swap_q <= cmp_done_q ? swap_q : (da < db);
            end
            i_q <= '0;
          end else begin
            if (da != db) begin
              cmp_done_q <= 1'b1;
              swap_q <= (da < db);
            end
            i_q <= i_q - 1'b1;
          end
        end
        ST_ADD: begin
          carry_q <= eff_add_q ? add_cy : sub_bw;
          if (wr_nz) begin
            top_q <= k_q; nz_q <= 1'b1;
          end
          if (wr_last) begin
            k_q <= top_fin;
            if (!nz_fin) sign_q <= 1'b0;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        ST_MUL: begin
          if (fin_q) begin
            // column done: keep its digit, carry the rest into the next one
            sum_q <= q10;
            fin_q <= 1'b0;
            i_q   <= '0;
            if (wr_nz) begin
              top_q <= k_q; nz_q <= 1'b1;
            end
            if (wr_last) begin
              k_q <= top_fin;
              if (!nz_fin) sign_q <= 1'b0;
            end else begin
              k_q <= k_q + 1'b1;
            end
          end else begin
            sum_q <= sum_nx;
            if (i_q == IdxW'(OperandDigits - 1)) fin_q <= 1'b1;
            else i_q <= i_q + 1'b1;
          end
        end
        ST_EMIT: if (emit_fire) begin
          rsp_q.digit_res    <= rd_q;
          rsp_q.negative_res <= sign_q;
          rsp_q.last         <= (k_q == '0);
          rsp_q.too_long     <= drop_q;
          if (k_q == '0) begin
            a_len_q <= '0; b_len_q <= '0; a_sign_q <= 1'b0; b_sign_q <= 1'b0;
            drop_q <= 1'b0;
          end else begin
            k_q <= k_q - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> req_stall_o)
    else $error("input taken while busy");
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_len_q <= LenW'(OperandDigits)) && (b_len_q <= LenW'(OperandDigits)))
    else $error("operand length overflow");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_stall_i) |=> (rsp_valid_o && $stable(rsp_o)))
    else $error("stalled result changed");
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (rsp_o.digit_res <= 4'd9))
    else $error("result digit out of range");

endmodule
`default_nettype wire
